>>> sv/mip_pkg.sv
// ----------------------------------------------------------------------------
// MIDI input packetizer package
// Shared payload types, register codes and the message length table.
// ----------------------------------------------------------------------------
`default_nettype none

package mip_pkg;

  // Byte codes
  localparam logic [7:0] SYSEX_END     = 8'hF7;
  localparam logic [7:0] REALTIME_BASE = 8'hF8;

  // Result kinds
  localparam logic KIND_STORED = 1'b0;
  localparam logic KIND_ECHO   = 1'b1;

  // Configuration register indexes
  localparam logic CFG_IDX_RX_ENABLE   = 1'b0;
  localparam logic CFG_IDX_THRU_ENABLE = 1'b1;

  // Number of results one byte can cause
  localparam int MAX_RESULTS = 3;

  // Expected message length by status bits 6..4
  localparam logic [2:0] LEN_TABLE [8] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd0
  };

  // Input request payload
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } in_item_t;

  // Result request payload
  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic        packet_start;
    logic [31:0] stamp_ms;
    logic        packet_end;
    logic [15:0] packet_bytes;
    logic        last;
  } out_item_t;

  // Configuration register contents
  typedef struct packed {
    logic rx_enable;
    logic thru_enable;
  } cfg_t;

  // All results of one byte, in emit order from slot 0
  typedef struct packed {
    logic [1:0]                       cnt;
    out_item_t [MAX_RESULTS-1:0]      slot;
  } bundle_t;

endpackage

`default_nettype wire

>>> sv/midi_input_packetizer_unit.sv
// ----------------------------------------------------------------------------
// MIDI input packetizer unit
// Parses received MIDI bytes into timestamped packets with running status
// reinsertion, and optionally echoes every byte while rx_enable is set.
//
//   Port group | Direction | Handshake        | Payload
//   in_        | input     | in_valid/ready   | rx_byte, now_ms
//   out_       | output    | out_valid/ready  | kind, out_byte, packet_start,
//              |           |                  | stamp_ms, packet_end,
//              |           |                  | packet_bytes, last
//   cfg_       | input     | cfg_we           | rx_enable, thru_enable
//
// A byte is registered on accept and parsed in the next cycle; its results
// are then loaded into the result sequencer slots and shown from there.
// The result sequencer emits one result per cycle while out_ready is high,
// so a byte causing n results (0 to 3) holds it until all have left; bytes
// with at most one result flow at one per cycle while out_ready is high.
// Reset is synchronous and clears the parser state, config registers, input valid and result count.
// Output stalls back up through the input register to in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_input_packetizer_unit
  import mip_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  // input channel
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  // result channel
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data,
  // configuration port
  input  wire logic     cfg_we,
  input  wire logic     cfg_index,
  input  wire logic     cfg_wdata
);

  cfg_t     cfg_r;
  logic     s1_valid_r;
  in_item_t s1_data_r;
  logic     seq_ready;
  logic     s1_adv;
  bundle_t  bundle;

  assign s1_adv   = s1_valid_r && seq_ready;
  assign in_ready = !s1_valid_r || seq_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_RX_ENABLE:   cfg_r.rx_enable   <= cfg_wdata;
        CFG_IDX_THRU_ENABLE: cfg_r.thru_enable <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  mip_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .item   (s1_data_r),
    .adv    (s1_adv),
    .bundle (bundle)
  );

  mip_out_seq u_out_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .bundle     (bundle),
    .load_valid (s1_valid_r),
    .load_ready (seq_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

>>> sv/mip_core.sv
// ----------------------------------------------------------------------------
// MIDI packetizer core
// Parser state and the single-pass logic that turns one byte into up to three
// results: reinserted running status, the stored byte and the thru echo.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_core
  import mip_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire in_item_t item,
  input  wire logic     adv,
  output bundle_t       bundle
);

  typedef struct packed {
    logic [7:0]  run_status;
    logic [2:0]  bytes_exp;   // two's complement, holds at -1
    logic        seen;
    logic [31:0] base_time;
    logic [15:0] since_end;
  } pstate_t;

  typedef struct packed {
    logic      emit;
    out_item_t res;
    pstate_t   st;
  } store_t;

  pstate_t state_r;
  pstate_t state_nxt;

  function automatic logic is_status(input logic [7:0] b);
    return b[7] && (b != SYSEX_END);
  endfunction

  // Store one byte into the packet stream
  function automatic store_t store(input pstate_t st, input logic [7:0] x,
                                   input logic [31:0] now);
    store_t r;
    logic   stat;
    r      = '0;
    r.st   = st;
    stat   = is_status(x);
    if (stat || st.seen) begin
      r.emit         = 1'b1;
      r.res.kind     = KIND_STORED;
      r.res.out_byte = x;
      if (stat) begin
        if (!st.seen) begin
          r.st.base_time = now;
          r.st.seen      = 1'b1;
          r.st.since_end = '0;
        end
        r.res.packet_start = 1'b1;
        r.res.stamp_ms     = now - r.st.base_time;
      end
      if (r.st.since_end != 16'hFFFF) begin
        r.st.since_end = r.st.since_end + 16'd1;
      end
      if (!r.st.bytes_exp[2]) begin
        r.st.bytes_exp = r.st.bytes_exp - 3'd1;
      end
      if ((r.st.bytes_exp == 3'd0) || (x == SYSEX_END)) begin
        r.res.packet_end   = 1'b1;
        r.res.packet_bytes = r.st.since_end;
        r.st.since_end     = '0;
      end
    end
    return r;
  endfunction

  // Build result bundle and next state
  always_comb begin
    pstate_t   st;
    store_t    s_a;
    store_t    s_b;
    out_item_t echo;
    logic [1:0] n;
    st     = state_r;
    s_a    = '0;
    s_b    = '0;
    echo   = '0;
    n      = 2'd0;
    bundle = '0;
    if (cfg.rx_enable) begin
      if (item.rx_byte < REALTIME_BASE) begin
        if (is_status(item.rx_byte)) begin
          st.run_status = item.rx_byte;
          st.bytes_exp  = LEN_TABLE[item.rx_byte[6:4]];
          s_b           = store(st, item.rx_byte, item.now_ms);
        end else if (st.bytes_exp == 3'd0) begin
          // data after a completed message: reinsert running status
          st.bytes_exp = LEN_TABLE[st.run_status[6:4]];
          s_a          = store(st, st.run_status, item.now_ms);
          s_b          = store(s_a.st, item.rx_byte, item.now_ms);
        end else begin
          s_b = store(st, item.rx_byte, item.now_ms);
        end
        st = s_b.st;
        if (s_a.emit) begin
          bundle.slot[n] = s_a.res;
          n              = n + 2'd1;
        end
        if (s_b.emit) begin
          bundle.slot[n] = s_b.res;
          n              = n + 2'd1;
        end
      end
      if (cfg.thru_enable) begin
        echo.kind      = KIND_ECHO;
        echo.out_byte  = item.rx_byte;
        bundle.slot[n] = echo;
        n              = n + 2'd1;
      end
      if (n != 2'd0) begin
        bundle.slot[n - 2'd1].last = 1'b1;
      end
    end
    bundle.cnt = n;
    state_nxt  = st;
  end

  // State register, updated as each byte is handed on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/mip_out_seq.sv
// ----------------------------------------------------------------------------
// MIDI packetizer result sequencer
// Holds the results of one byte and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_out_seq
  import mip_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire bundle_t bundle,
  input  wire logic    load_valid,
  output logic         load_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_item_t    out_data
);

  out_item_t [MAX_RESULTS-1:0] slot_r;
  logic [1:0]                  cnt_r;

  // Free when empty or when the final result leaves this cycle
  assign load_ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign out_valid  = (cnt_r != 2'd0);
  assign out_data   = slot_r[0];

  // Count of pending results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load_valid && load_ready) begin
      cnt_r <= bundle.cnt;
    end else if (out_valid && out_ready) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Result slots, shifted toward slot 0 as results leave
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      slot_r <= bundle.slot;
    end else if (out_valid && out_ready) begin
      slot_r <= {out_item_t'('0), slot_r[MAX_RESULTS-1:1]};
    end
  end

endmodule

`default_nettype wire
